/* rtl/tgad_pkg.sv */
package tgad_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int COORD_BITS      = 16;
    localparam int PAL_ADDR_BITS   = $clog2(PALETTE_ENTRIES);

    localparam int DIM_BITS        = 16;
    localparam int IDX_BITS        = 8;
    localparam int COLOR_BITS      = 24;
    localparam int VALUE_BITS      = 32;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [DIM_BITS:0] DIM_LIMIT = (DIM_BITS+1)'(2**COORD_BITS);
    localparam logic [IDX_BITS:0] PAL_LIMIT = (IDX_BITS+1)'(PALETTE_ENTRIES);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_KIND   = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2,
        CFG_HAS_ALPHA    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_TRUECOLOR = 2'd0,
        KIND_INDEXED   = 2'd1,
        KIND_GRAYSCALE = 2'd2
    } kind_t;

    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    typedef struct packed {
        logic [1:0]          image_kind;
        logic [DIM_BITS-1:0] image_width;
        logic [DIM_BITS-1:0] image_height;
        logic                has_alpha;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  last;
    } coord_t;

    // last valid coordinate for a dimension; zero acts as one, oversize clamps
    function automatic logic [COORD_BITS-1:0] last_index(input logic [DIM_BITS-1:0] dim);
        logic [DIM_BITS:0]   wide;
        logic [DIM_BITS-1:0] dec;
        wide = {1'b0, dim};
        dec  = dim - DIM_BITS'(1);
        if (dim == '0)
            last_index = '0;
        else if (wide > DIM_LIMIT)
            last_index = '1;
        else
            last_index = dec[COORD_BITS-1:0];
    endfunction

endpackage

/* rtl/tgad_ifs.sv */
interface tgad_in_if;
    import tgad_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [IDX_BITS-1:0]   palette_index;
    logic [COLOR_BITS-1:0] palette_color;
    logic [VALUE_BITS-1:0] pixel_value;

    modport source (
        output valid, req_type, palette_index, palette_color, pixel_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, palette_index, palette_color, pixel_value,
        output ready
    );
endinterface

interface tgad_out_if;
    import tgad_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DIM_BITS-1:0]   dest_row;
    logic [DIM_BITS-1:0]   dest_col;
    logic [VALUE_BITS-1:0] pixel_data;
    logic                  last_pixel;

    modport source (
        output valid, dest_row, dest_col, pixel_data, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, dest_row, dest_col, pixel_data, last_pixel,
        output ready
    );
endinterface

/* rtl/tgad_cfg.sv */
module tgad_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tgad_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tgad_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output tgad_pkg::cfg_t                       cfg
);
    import tgad_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_KIND:   cfg_next.image_kind   = cfg_data[1:0];
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[DIM_BITS-1:0];
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[DIM_BITS-1:0];
                CFG_HAS_ALPHA:    cfg_next.has_alpha    = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_kind   <= KIND_TRUECOLOR;
            cfg_reg.image_width  <= DIM_BITS'(1);
            cfg_reg.image_height <= DIM_BITS'(1);
            cfg_reg.has_alpha    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/tgad_palette.sv */
module tgad_palette (
    input  logic                                clk,
    input  logic                                we,
    input  logic [tgad_pkg::PAL_ADDR_BITS-1:0]  waddr,
    input  logic [tgad_pkg::COLOR_BITS-1:0]     wdata,
    input  logic                                re,
    input  logic [tgad_pkg::PAL_ADDR_BITS-1:0]  raddr,
    output logic [tgad_pkg::COLOR_BITS-1:0]     rdata
);
    import tgad_pkg::*;

    logic [COLOR_BITS-1:0] mem [PALETTE_ENTRIES];
    logic [COLOR_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tgad_coord.sv */
module tgad_coord (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tgad_pkg::cfg_t    cfg,
    output tgad_pkg::coord_t  crd
);
    import tgad_pkg::*;

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] line_reg, line_next;
    logic [COORD_BITS-1:0] last_col;
    logic [COORD_BITS-1:0] last_line;
    logic                  row_end;
    logic                  img_end;

    always_comb
    begin
        last_col  = last_index(cfg.image_width);
        last_line = last_index(cfg.image_height);
        row_end   = col_reg >= last_col;
        img_end   = row_end && (line_reg >= last_line);
        col_next  = col_reg;
        line_next = line_reg;
        if (step)
        begin
            if (row_end)
            begin
                col_next  = '0;
                line_next = img_end ? '0 : line_reg + COORD_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

    // row flip wraps modulo the coordinate range when counters overrun
    assign crd.row  = last_line - line_reg;
    assign crd.col  = col_reg;
    assign crd.last = img_end;

endmodule

/* rtl/tga_uncompressed_pixel_decoder_top.sv */
// Pipeline: an accepted pixel word loads the stage-1 registers and the palette
//   read register together, then moves on to the output register; a stall on
//   decoded.ready can hold it between the two.
// Throughput: one word per cycle, palette writes and pixels alike, while
//   decoded.ready does not hold the pipeline; a palette write gives no result.
// Reset: clears the registers to truecolor, 1x1, no alpha, zeroes the pixel
//   counters and empties the pipeline; the palette is not cleared.
module tga_uncompressed_pixel_decoder_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tgad_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tgad_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    tgad_in_if.sink                              pixels,
    tgad_out_if.source                           decoded
);
    import tgad_pkg::*;

    cfg_t   cfg;
    coord_t crd;

    logic acc_in;
    logic acc_pix;
    logic pal_we;
    logic out_adv;
    logic s1_adv;

    logic                  s1_v_reg, s1_v_next;
    coord_t                s1_crd_reg;
    logic [VALUE_BITS-1:0] s1_pix_reg;
    logic                  s1_idx_ok_reg;
    logic [COLOR_BITS-1:0] pal_rdata;

    logic                  out_v_reg, out_v_next;
    coord_t                out_crd_reg;
    logic [VALUE_BITS-1:0] out_data_reg, out_data_next;

    tgad_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tgad_coord u_coord (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (acc_pix),
        .cfg   (cfg),
        .crd   (crd)
    );

    tgad_palette u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pixels.palette_index[PAL_ADDR_BITS-1:0]),
        .wdata (pixels.palette_color),
        .re    (acc_pix),
        .raddr (pixels.pixel_value[PAL_ADDR_BITS-1:0]),
        .rdata (pal_rdata)
    );

    assign out_adv      = !out_v_reg || decoded.ready;
    assign s1_adv       = !s1_v_reg || out_adv;
    assign pixels.ready = s1_adv;
    assign acc_in       = pixels.valid && s1_adv;
    assign acc_pix      = acc_in && (pixels.req_type == REQ_PIXEL);
    assign pal_we       = acc_in && (pixels.req_type == REQ_PALETTE)
                          && ({1'b0, pixels.palette_index} < PAL_LIMIT);

    always_comb
    begin
        s1_v_next  = s1_adv ? acc_pix : s1_v_reg;
        out_v_next = out_adv ? s1_v_reg : out_v_reg;
    end

    always_comb
    begin
        case (cfg.image_kind)
            KIND_TRUECOLOR:
                out_data_next = cfg.has_alpha ? s1_pix_reg
                                              : {8'h00, s1_pix_reg[23:0]};
            KIND_INDEXED:
                out_data_next = s1_idx_ok_reg ? {8'h00, pal_rdata} : '0;
            default:
                out_data_next = {8'h00, s1_pix_reg[7:0], s1_pix_reg[7:0], s1_pix_reg[7:0]};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_pix)
        begin
            s1_crd_reg    <= crd;
            s1_pix_reg    <= pixels.pixel_value;
            s1_idx_ok_reg <= {1'b0, pixels.pixel_value[IDX_BITS-1:0]} < PAL_LIMIT;
        end
        if (out_adv && s1_v_reg)
        begin
            out_crd_reg  <= s1_crd_reg;
            out_data_reg <= out_data_next;
        end
    end

    assign decoded.valid      = out_v_reg;
    assign decoded.dest_row   = DIM_BITS'(out_crd_reg.row);
    assign decoded.dest_col   = DIM_BITS'(out_crd_reg.col);
    assign decoded.pixel_data = out_data_reg;
    assign decoded.last_pixel = out_crd_reg.last;

`ifndef NO_ASSERTIONS
    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_pix && crd.last) |=> (crd.col == '0))
        else $error("pixel counters not cleared after last pixel");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && !s1_adv) |=> ($stable(s1_pix_reg) && $stable(pal_rdata)))
        else $error("stalled pixel stage changed");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && out_v_reg && !decoded.ready) |-> !pixels.ready)
        else $error("word accepted while pipeline full");
`endif

endmodule
